// ----- rtl/whp_pkg.sv -----
// Shared types, constants and helpers of the WAVE header parser.
`default_nettype none

package whp_pkg;

   localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;
   localparam int unsigned RSP_DATA_W          = 152;

   localparam logic [31:0] ID_RIFF = 32'h5249_4646;
   localparam logic [31:0] ID_RIFX = 32'h5249_4658;
   localparam logic [31:0] ID_WAVE = 32'h5741_5645;
   localparam logic [31:0] ID_FMT  = 32'h666D_7420;
   localparam logic [31:0] ID_DATA = 32'h6461_7461;

   localparam logic [31:0] FMT_FIELD_BYTES = 32'd16;
   localparam logic [15:0] FORMAT_PCM      = 16'd1;

   typedef enum logic [1:0] {
      KIND_FORMAT = 2'd0,
      KIND_SAMPLE = 2'd1,
      KIND_ERROR  = 2'd2,
      KIND_DONE   = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ERR_NONE      = 2'd0,
      ERR_FMT_SHORT = 2'd1,
      ERR_EXTRA     = 2'd2,
      ERR_TRUNCATED = 2'd3
   } err_type;

   typedef enum logic [14:0] {
      PH_SCAN  = 15'b000_0000_0000_0001,
      PH_RSIZE = 15'b000_0000_0000_0010,
      PH_RFORM = 15'b000_0000_0000_0100,
      PH_FSIZE = 15'b000_0000_0000_1000,
      PH_TAG   = 15'b000_0000_0001_0000,
      PH_CH    = 15'b000_0000_0010_0000,
      PH_RATE  = 15'b000_0000_0100_0000,
      PH_BRATE = 15'b000_0000_1000_0000,
      PH_ALIGN = 15'b000_0001_0000_0000,
      PH_BITS  = 15'b000_0010_0000_0000,
      PH_EXTRA = 15'b000_0100_0000_0000,
      PH_SKIP  = 15'b000_1000_0000_0000,
      PH_DSIZE = 15'b001_0000_0000_0000,
      PH_DATA  = 15'b010_0000_0000_0000,
      PH_HALT  = 15'b100_0000_0000_0000
   } phase_type;

   typedef struct packed {
      logic        rifx_order;
      logic        is_wave;
      logic [15:0] format_tag;
      logic [15:0] channels;
      logic [31:0] samples_per_sec;
      logic [31:0] byte_rate;
      logic [15:0] block_align;
      logic [15:0] bits_per_sample;
   } header_type;

   typedef struct packed {
      header_type  hdr;
      kind_type    kind0;
      logic [15:0] sample0;
      err_type     err0;
      logic        has_second;
      kind_type    kind1;
      err_type     err1;
   } entry_type;

   typedef struct packed {
      header_type  hdr;
      kind_type    kind;
      logic [15:0] sample;
      err_type     err;
      logic        last;
   } result_type;

   function automatic logic [31:0] swap32(input logic [31:0] x);
      return {x[7:0], x[15:8], x[23:16], x[31:24]};
   endfunction

   function automatic logic [15:0] swap16(input logic [15:0] x);
      return {x[7:0], x[15:8]};
   endfunction

endpackage

`default_nettype wire

// ----- rtl/wave_header_parser_top.sv -----
// Top level of the RIFF/RIFX WAVE header parser.
`default_nettype none

// The parser takes one file byte per clock cycle while the queue is not full, and
// keeps that rate for every byte that yields at most one result; the front end
// decides each byte combinationally and writes its results into a queue of
// QUEUE_DEPTH entries. A byte that yields two results (format info then an error,
// or a result then done or the truncation error) holds the output register for
// both, which the queue absorbs. Results leave through a registered output stage,
// so the first result of a byte passes the queue and then the output register.
// After an error or done result the parser takes further bytes silently until reset.
module wave_header_parser_top
   import whp_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // file_byte
   input  wire logic [7:0]            req_tdata,
   input  wire logic                  req_tlast,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // rifx_order, is_wave, format_tag, channels, samples_per_sec, byte_rate,
   // block_align, bits_per_sample, sample, error_code, zero fill
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // kind
   output logic [1:0]                 rsp_tuser,
   output logic                       rsp_tlast
);

   entry_type push_entry;
   entry_type head;
   logic      push;
   logic      pop;
   logic      empty;
   logic      full;

   whp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .q_full     (full),
      .q_push     (push),
      .q_entry    (push_entry)
   );

   whp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   whp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (empty),
      .q_head     (head),
      .q_pop      (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

`default_nettype wire

// ----- rtl/whp_front.sv -----
// Front end: takes file bytes, tracks the chunk structure and builds queue entries.
`default_nettype none

module whp_front
   import whp_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      req_tvalid,
   input  wire logic [7:0] req_tdata,
   input  wire logic      req_tlast,
   output logic           req_tready,
   input  wire logic      q_full,
   output logic           q_push,
   output entry_type      q_entry
);

   phase_type   phase_ff, phase_in;
   logic [2:0]  pos_ff, pos_in;
   logic [31:0] asm_ff, asm_in;
   logic [31:0] left_ff, left_in;
   logic        endian_ff, endian_in;
   logic        wave_ff, wave_in;
   logic [15:0] tag_ff, tag_in;
   logic [15:0] ch_ff, ch_in;
   logic [31:0] rate_ff, rate_in;
   logic [31:0] brate_ff, brate_in;
   logic [15:0] align_ff, align_in;
   logic [15:0] bits_ff, bits_in;

   logic        accept;
   logic [15:0] v16;
   logic [31:0] v32;
   logic [31:0] left_dec;
   logic [31:0] left_less2;
   logic [2:0]  pos_inc;
   logic        any;

   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;
   assign asm_in     = accept && (phase_ff != PH_HALT) ? {asm_ff[23:0], req_tdata} : asm_ff;
   assign v16        = endian_ff ? asm_in[15:0] : swap16(asm_in[15:0]);
   assign v32        = endian_ff ? asm_in : swap32(asm_in);
   assign left_dec   = left_ff - 32'd1;
   assign left_less2 = left_ff - 32'd2;
   assign pos_inc    = pos_ff + 3'd1;

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      left_in   = left_ff;
      endian_in = endian_ff;
      wave_in   = wave_ff;
      tag_in    = tag_ff;
      ch_in     = ch_ff;
      rate_in   = rate_ff;
      brate_in  = brate_ff;
      align_in  = align_ff;
      bits_in   = bits_ff;
      any                = 1'b0;
      q_entry.kind0      = KIND_FORMAT;
      q_entry.sample0    = 16'd0;
      q_entry.err0       = ERR_NONE;
      q_entry.has_second = 1'b0;
      q_entry.kind1      = KIND_FORMAT;
      q_entry.err1       = ERR_NONE;
      if (accept && phase_ff != PH_HALT) begin
         unique case (phase_ff)
            PH_SCAN: begin
               pos_in = pos_inc;
               if (pos_inc >= 3'd4) begin
                  pos_in = 3'd0;
                  if (asm_in == ID_RIFF) begin
                     endian_in = 1'b0;
                     phase_in  = PH_RSIZE;
                  end else if (asm_in == ID_RIFX) begin
                     endian_in = 1'b1;
                     phase_in  = PH_RSIZE;
                  end else if (asm_in == ID_FMT) begin
                     phase_in = PH_FSIZE;
                  end else if (asm_in == ID_DATA) begin
                     phase_in = PH_DSIZE;
                  end
               end
            end
            PH_SKIP: begin
               left_in = left_dec;
               if (left_dec == 32'd0) phase_in = PH_SCAN;
            end
            PH_DATA: begin
               left_in   = left_dec;
               pos_in    = {pos_ff[2:1], ~pos_ff[0]};
               if (pos_ff[0]) begin
                  any             = 1'b1;
                  q_entry.kind0   = KIND_SAMPLE;
                  q_entry.sample0 = v16;
               end
               if (left_dec == 32'd0) begin
                  pos_in   = 3'd0;
                  phase_in = PH_SCAN;
               end
            end
            PH_TAG, PH_CH, PH_ALIGN, PH_BITS, PH_EXTRA: begin
               pos_in = pos_inc;
               if (pos_inc >= 3'd2) begin
                  pos_in = 3'd0;
                  unique case (phase_ff)
                     PH_TAG: begin
                        tag_in   = v16;
                        phase_in = PH_CH;
                     end
                     PH_CH: begin
                        ch_in    = v16;
                        phase_in = PH_RATE;
                     end
                     PH_ALIGN: begin
                        align_in = v16;
                        phase_in = PH_BITS;
                     end
                     PH_BITS: begin
                        bits_in       = v16;
                        any           = 1'b1;
                        q_entry.kind0 = KIND_FORMAT;
                        if (left_ff == 32'd0) begin
                           phase_in = PH_SCAN;
                        end else if (tag_ff == FORMAT_PCM) begin
                           phase_in = PH_SKIP;
                        end else if (left_ff < 32'd2) begin
                           q_entry.has_second = 1'b1;
                           q_entry.kind1      = KIND_ERROR;
                           q_entry.err1       = ERR_EXTRA;
                           phase_in           = PH_HALT;
                        end else begin
                           phase_in = PH_EXTRA;
                        end
                     end
                     default: begin
                        left_in = left_less2;
                        if (left_less2 != {16'd0, v16}) begin
                           any           = 1'b1;
                           q_entry.kind0 = KIND_ERROR;
                           q_entry.err0  = ERR_EXTRA;
                           phase_in      = PH_HALT;
                        end else begin
                           phase_in = (left_less2 == 32'd0) ? PH_SCAN : PH_SKIP;
                        end
                     end
                  endcase
               end
            end
            default: begin
               pos_in = pos_inc;
               if (pos_inc >= 3'd4) begin
                  pos_in = 3'd0;
                  unique case (phase_ff)
                     PH_RSIZE: phase_in = PH_RFORM;
                     PH_RFORM: begin
                        wave_in  = (v32 == ID_WAVE);
                        phase_in = PH_SCAN;
                     end
                     PH_FSIZE: begin
                        if (v32 < FMT_FIELD_BYTES) begin
                           any           = 1'b1;
                           q_entry.kind0 = KIND_ERROR;
                           q_entry.err0  = ERR_FMT_SHORT;
                           phase_in      = PH_HALT;
                        end else begin
                           left_in  = v32 - FMT_FIELD_BYTES;
                           phase_in = PH_TAG;
                        end
                     end
                     PH_RATE: begin
                        rate_in  = v32;
                        phase_in = PH_BRATE;
                     end
                     PH_BRATE: begin
                        brate_in = v32;
                        phase_in = PH_ALIGN;
                     end
                     PH_DSIZE: begin
                        left_in  = v32;
                        phase_in = (v32 == 32'd0) ? PH_SCAN : PH_DATA;
                     end
                     default: phase_in = PH_HALT;
                  endcase
               end
            end
         endcase
         if (req_tlast && phase_in != PH_HALT) begin
            if (any) begin
               q_entry.has_second = 1'b1;
               q_entry.kind1      = (phase_in == PH_SCAN) ? KIND_DONE : KIND_ERROR;
               q_entry.err1       = (phase_in == PH_SCAN) ? ERR_NONE : ERR_TRUNCATED;
            end else begin
               q_entry.kind0 = (phase_in == PH_SCAN) ? KIND_DONE : KIND_ERROR;
               q_entry.err0  = (phase_in == PH_SCAN) ? ERR_NONE : ERR_TRUNCATED;
            end
            any      = 1'b1;
            phase_in = PH_HALT;
         end
      end
      q_push                      = any;
      q_entry.hdr.rifx_order      = endian_in;
      q_entry.hdr.is_wave         = wave_in;
      q_entry.hdr.format_tag      = tag_in;
      q_entry.hdr.channels        = ch_in;
      q_entry.hdr.samples_per_sec = rate_in;
      q_entry.hdr.byte_rate       = brate_in;
      q_entry.hdr.block_align     = align_in;
      q_entry.hdr.bits_per_sample = bits_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_SCAN;
         pos_ff    <= 3'd0;
         asm_ff    <= 32'd0;
         left_ff   <= 32'd0;
         endian_ff <= 1'b0;
         wave_ff   <= 1'b0;
         tag_ff    <= 16'd0;
         ch_ff     <= 16'd0;
         rate_ff   <= 32'd0;
         brate_ff  <= 32'd0;
         align_ff  <= 16'd0;
         bits_ff   <= 16'd0;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         asm_ff    <= asm_in;
         left_ff   <= left_in;
         endian_ff <= endian_in;
         wave_ff   <= wave_in;
         tag_ff    <= tag_in;
         ch_ff     <= ch_in;
         rate_ff   <= rate_in;
         brate_ff  <= brate_in;
         align_ff  <= align_in;
         bits_ff   <= bits_in;
      end
   end

   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HALT |=> phase_ff == PH_HALT)
      else $error("Parser left the halted phase without reset.");

   a_halt_silent: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HALT |-> !q_push)
      else $error("Halted parser produced a queue entry.");

endmodule

`default_nettype wire

// ----- rtl/whp_queue.sv -----
// Short register queue of parsed entries between the front and back ends.
`default_nettype none

module whp_queue
   import whp_pkg::*;
#(
   parameter int unsigned DEPTH = QUEUE_DEPTH_DEFAULT
)(
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic push,
   input  entry_type push_entry,
   input  wire logic pop,
   output entry_type head,
   output logic      empty,
   output logic      full
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type        slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in;
   logic [PTR_W-1:0] rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign empty = (cnt_ff == '0);
   assign full  = (cnt_ff == FULL_CNT);
   assign head  = slot_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + PTR_W'(1);
      if (pop)  rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + PTR_W'(1);
      if (push && !pop) cnt_in = cnt_ff + CNT_W'(1);
      else if (!push && pop) cnt_in = cnt_ff - CNT_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ff] <= push_entry;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("Entry pushed into a full queue.");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("Entry popped from an empty queue.");

endmodule

`default_nettype wire

// ----- rtl/whp_back.sv -----
// Back end: unpacks queue entries into one or two results behind an output register.
`default_nettype none

module whp_back
   import whp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  q_empty,
   input  entry_type                  q_head,
   output logic                       q_pop,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // rifx_order, is_wave, format_tag, channels, samples_per_sec, byte_rate,
   // block_align, bits_per_sample, sample, error_code, zero fill
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   // kind
   output logic [1:0]                 rsp_tuser,
   output logic                       rsp_tlast
);

   result_type out_ff, out_in;
   result_type second_ff, second_in;
   logic       valid_ff, valid_in;
   logic       pend_ff, pend_in;
   logic       load;

   assign load = !valid_ff || rsp_tready;

   always_comb begin
      out_in    = out_ff;
      second_in = second_ff;
      valid_in  = valid_ff && !rsp_tready;
      pend_in   = pend_ff;
      q_pop     = 1'b0;
      if (load) begin
         if (pend_ff) begin
            out_in   = second_ff;
            valid_in = 1'b1;
            pend_in  = 1'b0;
         end else if (!q_empty) begin
            q_pop          = 1'b1;
            valid_in       = 1'b1;
            pend_in        = q_head.has_second;
            out_in.hdr     = q_head.hdr;
            out_in.kind    = q_head.kind0;
            out_in.sample  = q_head.sample0;
            out_in.err     = q_head.err0;
            out_in.last    = !q_head.has_second;
            second_in.hdr    = q_head.hdr;
            second_in.kind   = q_head.kind1;
            second_in.sample = 16'd0;
            second_in.err    = q_head.err1;
            second_in.last   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff    <= out_in;
      second_ff <= second_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tuser  = out_ff.kind;
   assign rsp_tlast  = out_ff.last;
   assign rsp_tdata  = {4'd0, out_ff.err, out_ff.sample, out_ff.hdr.bits_per_sample,
                        out_ff.hdr.block_align, out_ff.hdr.byte_rate,
                        out_ff.hdr.samples_per_sec, out_ff.hdr.channels,
                        out_ff.hdr.format_tag, out_ff.hdr.is_wave,
                        out_ff.hdr.rifx_order};

   a_pend_behind_valid: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> valid_ff && !out_ff.last)
      else $error("Second result pending without a first result in the output register.");

endmodule

`default_nettype wire

// ----- tb/sv/wave_result_checker.sv -----
// Checker that predicts the parser's results from accepted requests and compares them.
module wave_result_checker
   import whp_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   // file_byte
   input  wire logic [7:0]            req_tdata,
   input  wire logic                  req_tlast,
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   // rifx_order, is_wave, format_tag, channels, samples_per_sec, byte_rate,
   // block_align, bits_per_sample, sample, error_code, zero fill
   input  wire logic [RSP_DATA_W-1:0] rsp_tdata,
   // kind
   input  wire logic [1:0]            rsp_tuser,
   input  wire logic                  rsp_tlast,
   output int                         fail_count,
   output int                         results_pending,
   output int                         results_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   phase_type   phase;
   logic [2:0]  pos;
   logic [31:0] word;
   logic [31:0] bytes_to_go;
   logic [15:0] extra_len;
   header_type  hdr;
   result_type  expected_q[$];

   // Value of the last two or four bytes taken, in the container's byte order.
   function automatic logic [31:0] word_value(input int len);
      logic [15:0] low;
      low = word[15:0];
      if (len == 2)
         return hdr.rifx_order ? {16'd0, low} : {16'd0, low[7:0], low[15:8]};
      return hdr.rifx_order ? word : {word[7:0], word[15:8], word[23:16], word[31:24]};
   endfunction

   function automatic int field_len(input phase_type ph);
      return (ph inside {PH_TAG, PH_CH, PH_ALIGN, PH_BITS, PH_EXTRA}) ? 2 : 4;
   endfunction

   function automatic result_type make_result(input kind_type k, input logic [15:0] s,
                                              input err_type e);
      result_type r;
      r.hdr    = hdr;
      r.kind   = k;
      r.sample = s;
      r.err    = e;
      r.last   = 1'b0;
      return r;
   endfunction

   task automatic clear_parse_state();
      phase       = PH_SCAN;
      pos         = 3'd0;
      word        = 32'd0;
      bytes_to_go = 32'd0;
      extra_len   = 16'd0;
      hdr         = '0;
      expected_q.delete();
   endtask

   task automatic predict_byte(input logic [7:0] b, input logic eof);
      result_type  res [2];
      int          n;
      logic [31:0] v;
      n = 0;
      if (phase == PH_HALT)
         return;
      word = {word[23:0], b};
      case (phase)
         PH_SCAN: begin
            pos = pos + 3'd1;
            if (pos >= 3'd4) begin
               pos = 3'd0;
               if (word == ID_RIFF) begin
                  hdr.rifx_order = 1'b0;
                  phase = PH_RSIZE;
               end else if (word == ID_RIFX) begin
                  hdr.rifx_order = 1'b1;
                  phase = PH_RSIZE;
               end else if (word == ID_FMT) begin
                  phase = PH_FSIZE;
               end else if (word == ID_DATA) begin
                  phase = PH_DSIZE;
               end
            end
         end
         PH_SKIP: begin
            bytes_to_go = bytes_to_go - 32'd1;
            if (bytes_to_go == 32'd0)
               phase = PH_SCAN;
         end
         PH_DATA: begin
            bytes_to_go = bytes_to_go - 32'd1;
            pos = pos ^ 3'd1;
            if (pos == 3'd0) begin
               v = word_value(2);
               res[n] = make_result(KIND_SAMPLE, v[15:0], ERR_NONE);
               n++;
            end
            if (bytes_to_go == 32'd0) begin
               pos = 3'd0;
               phase = PH_SCAN;
            end
         end
         default: begin
            pos = pos + 3'd1;
            if (int'(pos) >= field_len(phase)) begin
               pos = 3'd0;
               v = word_value(field_len(phase));
               case (phase)
                  PH_RSIZE: phase = PH_RFORM;
                  PH_RFORM: begin
                     hdr.is_wave = (v == ID_WAVE);
                     phase = PH_SCAN;
                  end
                  PH_FSIZE: begin
                     if (v < FMT_FIELD_BYTES) begin
                        res[n] = make_result(KIND_ERROR, 16'd0, ERR_FMT_SHORT);
                        n++;
                        phase = PH_HALT;
                     end else begin
                        bytes_to_go = v - FMT_FIELD_BYTES;
                        phase = PH_TAG;
                     end
                  end
                  PH_TAG: begin
                     hdr.format_tag = v[15:0];
                     phase = PH_CH;
                  end
                  PH_CH: begin
                     hdr.channels = v[15:0];
                     phase = PH_RATE;
                  end
                  PH_RATE: begin
                     hdr.samples_per_sec = v;
                     phase = PH_BRATE;
                  end
                  PH_BRATE: begin
                     hdr.byte_rate = v;
                     phase = PH_ALIGN;
                  end
                  PH_ALIGN: begin
                     hdr.block_align = v[15:0];
                     phase = PH_BITS;
                  end
                  PH_BITS: begin
                     hdr.bits_per_sample = v[15:0];
                     res[n] = make_result(KIND_FORMAT, 16'd0, ERR_NONE);
                     n++;
                     if (bytes_to_go == 32'd0) begin
                        phase = PH_SCAN;
                     end else if (hdr.format_tag == FORMAT_PCM) begin
                        phase = PH_SKIP;
                     end else if (bytes_to_go < 32'd2) begin
                        res[n] = make_result(KIND_ERROR, 16'd0, ERR_EXTRA);
                        n++;
                        phase = PH_HALT;
                     end else begin
                        phase = PH_EXTRA;
                     end
                  end
                  PH_EXTRA: begin
                     extra_len = v[15:0];
                     bytes_to_go = bytes_to_go - 32'd2;
                     if (bytes_to_go != {16'd0, extra_len}) begin
                        res[n] = make_result(KIND_ERROR, 16'd0, ERR_EXTRA);
                        n++;
                        phase = PH_HALT;
                     end else begin
                        phase = (bytes_to_go == 32'd0) ? PH_SCAN : PH_SKIP;
                     end
                  end
                  PH_DSIZE: begin
                     bytes_to_go = v;
                     phase = (v == 32'd0) ? PH_SCAN : PH_DATA;
                  end
                  default: phase = PH_HALT;
               endcase
            end
         end
      endcase

      if (eof && phase != PH_HALT) begin
         if (phase == PH_SCAN)
            res[n] = make_result(KIND_DONE, 16'd0, ERR_NONE);
         else
            res[n] = make_result(KIND_ERROR, 16'd0, ERR_TRUNCATED);
         n++;
         phase = PH_HALT;
      end
      for (int i = 0; i < n; i++) begin
         res[i].last = (i == n - 1);
         expected_q.push_back(res[i]);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   task automatic compare_result();
      result_type want;
      if (expected_q.size() == 0) begin
         $error("Result of kind %0d arrived with nothing outstanding", rsp_tuser);
         fail_count++;
         return;
      end
      want = expected_q.pop_front();
      results_checked++;
      check_field("kind", 32'(want.kind), 32'(rsp_tuser));
      check_field("rifx_order", 32'(want.hdr.rifx_order), 32'(rsp_tdata[0]));
      check_field("is_wave", 32'(want.hdr.is_wave), 32'(rsp_tdata[1]));
      check_field("format_tag", 32'(want.hdr.format_tag), 32'(rsp_tdata[17:2]));
      check_field("channels", 32'(want.hdr.channels), 32'(rsp_tdata[33:18]));
      check_field("samples_per_sec", want.hdr.samples_per_sec, rsp_tdata[65:34]);
      check_field("byte_rate", want.hdr.byte_rate, rsp_tdata[97:66]);
      check_field("block_align", 32'(want.hdr.block_align), 32'(rsp_tdata[113:98]));
      check_field("bits_per_sample", 32'(want.hdr.bits_per_sample),
                  32'(rsp_tdata[129:114]));
      check_field("sample", 32'(want.sample), 32'(rsp_tdata[145:130]));
      check_field("error_code", 32'(want.err), 32'(rsp_tdata[147:146]));
      check_field("last", 32'(want.last), 32'(rsp_tlast));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_parse_state();
         fail_count      = 0;
         results_checked = 0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            compare_result();
         if (req_tvalid && req_tready)
            predict_byte(req_tdata, req_tlast);
      end
      results_pending = expected_q.size();
   end

endmodule

// ----- tb/sv/tb_wave_header_parser_top.sv -----
// Testbench top: builds a WAVE byte stream, drives the parser and gives the verdict.
module tb_wave_header_parser_top;
   import whp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_BYTES = 800;
   localparam int STALL_LIMIT  = 2000;
   localparam int HOLD_CYCLES  = 300;
   localparam int HOLD_AT      = 350;
   localparam int PAUSE_AT     = 550;
   localparam int BURST_FROM   = 120;
   localparam int BURST_TO     = 300;
   localparam int QUIET_FROM   = 200;
   localparam int QUIET_TO     = 500;
   localparam int DRAIN_CYCLES = 20;

   typedef enum int {
      END_DONE, END_TRUNCATED, END_FMT_SHORT, END_NO_EXTRA, END_EXTRA_MISMATCH
   } ending_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [7:0]            req_tdata;
   logic                  req_tlast;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0]            rsp_tuser;
   logic                  rsp_tlast;
   int                    fail_count;
   int                    results_pending;
   int                    results_checked;

   logic [7:0] file_bytes[$];
   bit         gen_be = 1'b0;
   bit         hold_request = 1'b0;
   ending_type ending;

   wave_header_parser_top dut (.*);

   wave_result_checker result_check (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tdata, .req_tlast,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tuser, .rsp_tlast,
      .fail_count, .results_pending, .results_checked
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] pick16();
      case ($urandom_range(0, 5))
         0: return 16'h0000;
         1: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick32();
      case ($urandom_range(0, 5))
         0: return 32'h0000_0000;
         1: return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [15:0] pick_coded_tag();
      logic [15:0] t;
      t = pick16();
      return (t == FORMAT_PCM) ? 16'h0003 : t;
   endfunction

   task automatic put_id(input logic [31:0] id);
      file_bytes.push_back(id[31:24]);
      file_bytes.push_back(id[23:16]);
      file_bytes.push_back(id[15:8]);
      file_bytes.push_back(id[7:0]);
   endtask

   task automatic put32(input logic [31:0] v);
      put_id(gen_be ? v : {v[7:0], v[15:8], v[23:16], v[31:24]});
   endtask

   task automatic put16(input logic [15:0] v);
      if (gen_be) begin
         file_bytes.push_back(v[15:8]);
         file_bytes.push_back(v[7:0]);
      end else begin
         file_bytes.push_back(v[7:0]);
         file_bytes.push_back(v[15:8]);
      end
   endtask

   task automatic put_noise(input int n);
      repeat (n) file_bytes.push_back(8'($urandom));
   endtask

   task automatic put_riff(input bit be, input bit wave);
      gen_be = be;
      put_id(be ? ID_RIFX : ID_RIFF);
      put32(pick32());
      put_id(wave ? ID_WAVE : $urandom);
   endtask

   task automatic put_fmt(input logic [15:0] tag, ch, input logic [31:0] rate, brate,
                          input logic [15:0] align, bits, input logic [31:0] size,
                          input logic [15:0] extra_field);
      int rem;
      put_id(ID_FMT);
      put32(size);
      if (size < FMT_FIELD_BYTES)
         return;
      put16(tag);
      put16(ch);
      put32(rate);
      put32(brate);
      put16(align);
      put16(bits);
      rem = int'(size - FMT_FIELD_BYTES);
      if (tag != FORMAT_PCM && rem >= 2) begin
         put16(extra_field);
         rem -= 2;
      end
      put_noise(rem);
   endtask

   task automatic put_random_fmt();
      logic [15:0] tag;
      int          extra;
      tag = $urandom_range(0, 1) ? FORMAT_PCM : pick_coded_tag();
      extra = $urandom_range(0, 4);
      if (tag == FORMAT_PCM)
         put_fmt(tag, pick16(), pick32(), pick32(), pick16(), pick16(),
                 FMT_FIELD_BYTES + 32'(extra), 16'd0);
      else if ($urandom_range(0, 3) == 0)
         put_fmt(tag, pick16(), pick32(), pick32(), pick16(), pick16(),
                 FMT_FIELD_BYTES, 16'd0);
      else
         put_fmt(tag, pick16(), pick32(), pick32(), pick16(), pick16(),
                 FMT_FIELD_BYTES + 32'(extra + 2), 16'(extra));
   endtask

   task automatic put_data(input int n);
      put_id(ID_DATA);
      put32(32'(n));
      put_noise(n);
   endtask

   task automatic put_junk();
      logic [31:0] w;
      if ($urandom_range(0, 3) == 0) begin
         put_id(ID_WAVE);
      end else begin
         do w = $urandom;
         while (w == ID_RIFF || w == ID_RIFX || w == ID_FMT || w == ID_DATA);
         put_id(w);
      end
   endtask

   task automatic build_file();
      int first_random;
      int n;
      // A big-endian header with extreme format fields and an odd data chunk.
      put_riff(1'b1, 1'b1);
      put_fmt(FORMAT_PCM, 16'hFFFF, 32'hFFFF_FFFF, 32'h0, 16'h0, 16'hFFFF,
              FMT_FIELD_BYTES, 16'd0);
      put_data(3);

      first_random = file_bytes.size();
      while (file_bytes.size() < first_random + RANDOM_BYTES) begin
         case ($urandom_range(0, 9))
            0:       put_riff(1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0);
            1, 2:    put_random_fmt();
            8, 9:    put_junk();
            default: put_data(($urandom_range(0, 7) == 0) ? $urandom_range(25, 64)
                                                          : $urandom_range(0, 24));
         endcase
      end

      // The parser halts at the end of a file, so each run closes with one ending.
      ending = ending_type'($urandom_range(0, 4));
      case (ending)
         END_DONE: put_data($urandom_range(1, 4));
         END_TRUNCATED: begin
            put_id(ID_DATA);
            put32(32'd40);
            put_noise(5);
         end
         END_FMT_SHORT: begin
            put_fmt(pick16(), pick16(), pick32(), pick32(), pick16(), pick16(),
                    32'($urandom_range(0, 15)), 16'd0);
            put_noise(3);
         end
         END_NO_EXTRA: begin
            put_fmt(pick_coded_tag(), pick16(), pick32(), pick32(), pick16(), pick16(),
                    FMT_FIELD_BYTES + 32'd1, 16'd0);
            put_noise(3);
         end
         default: begin
            n = $urandom_range(0, 3);
            put_fmt(pick_coded_tag(), pick16(), pick32(), pick32(), pick16(), pick16(),
                    FMT_FIELD_BYTES + 32'(n + 2), 16'(n + 1 + $urandom_range(0, 100)));
            put_noise(3);
         end
      endcase
   endtask

   initial begin : sender
      bit burst;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = 8'd0;
      req_tlast  = 1'b0;
      build_file();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int idx = 0; idx < file_bytes.size(); idx++) begin
         if (idx == PAUSE_AT) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
            while (results_pending != 0) @(negedge clock);
         end
         if (idx == HOLD_AT)
            hold_request = 1'b1;
         burst = (idx >= BURST_FROM && idx < BURST_TO);
         while (!burst && $urandom_range(0, 99) < 23) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= file_bytes[idx];
         req_tlast  <= (idx == file_bytes.size() - 1);
         do @(posedge clock); while (!req_tready);
         @(negedge clock);
      end
      req_tvalid <= 1'b0;

      while (results_pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Streamed %0d file bytes in both byte orders and checked %0d results.",
               file_bytes.size(), results_checked);
      $display("The file closed with %s after a long output stall and a drain pause.",
               ending.name());
      if (fail_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

   initial begin : receiver
      int  cycle;
      int  hold_left;
      bit  held;
      cycle      = 0;
      hold_left  = 0;
      held       = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         cycle++;
         if (hold_request && !held) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (cycle >= QUIET_FROM && cycle < QUIET_TO) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(0, 99) >= 23);
         end
      end
   end

   initial begin : watchdog
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            stalled = 0;
         else
            stalled++;
      end
      $display("Simulation FAILED");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/whp_pkg.sv
rtl/whp_front.sv
rtl/whp_queue.sv
rtl/whp_back.sv
rtl/wave_header_parser_top.sv
tb/sv/wave_result_checker.sv
tb/sv/tb_wave_header_parser_top.sv
